// File: design/strip_fan_triangle_assembler_macros.svh
// ----------------------------------------------------------------------------
// Strip and fan triangle assembler assertion macros
// Shared concurrent assertion forms used by the assembler's modules.
// ----------------------------------------------------------------------------
`ifndef STRIP_FAN_TRIANGLE_ASSEMBLER_MACROS_SVH
`define STRIP_FAN_TRIANGLE_ASSEMBLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assembler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assembler check failed");

`endif

// File: design/stfa_pkg.sv
// ----------------------------------------------------------------------------
// Strip and fan triangle assembler package
// Vertex and triangle types and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package stfa_pkg;

    localparam int unsigned IDX_W   = 15;
    localparam int unsigned CRD_W   = 16;
    localparam int unsigned COUNT_W = 16;

    // Item type codes carried on req_type.
    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_VERTEX = 1'b1;

    // Saturating vertex counter values.
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [CRD_W-1:0] s;
        logic signed [CRD_W-1:0] t;
    } vertex_t;

    typedef struct packed {
        vertex_t corner0;
        vertex_t corner1;
        vertex_t corner2;
        logic    run_end;
    } tri_t;

endpackage

`default_nettype wire

// File: design/stfa_core.sv
// ----------------------------------------------------------------------------
// Strip and fan triangle assembler core
// Run state and vertex history; forms one triangle per accepted vertex from the third vertex of a run on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "strip_fan_triangle_assembler_macros.svh"

module stfa_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic                           req_type,
    input  wire logic signed [15:0]             run_count,
    input  wire logic [14:0]                    vertex_index,
    input  wire logic signed [15:0]             tex_s,
    input  wire logic signed [15:0]             tex_t,
    output logic                                emit,
    output stfa_pkg::tri_t                      emit_tri
);
    import stfa_pkg::*;

    logic               fan_mode_reg, fan_mode_next;
    logic [COUNT_W-1:0] vleft_reg, vleft_next;
    logic [1:0]         seen_reg, seen_next;
    vertex_t            center_reg, center_next;
    vertex_t            last_reg, last_next;
    vertex_t            second_last_reg, second_last_next;

    logic    hdr_take;
    logic    vtx_take;
    vertex_t cur;

    assign hdr_take = accept && (req_type == REQ_HEADER);
    assign vtx_take = accept && (req_type == REQ_VERTEX) && (vleft_reg != '0);

    assign cur.index = vertex_index;
    assign cur.s     = tex_s;
    assign cur.t     = tex_t;

    always_comb
    begin
        fan_mode_next    = fan_mode_reg;
        vleft_next       = vleft_reg;
        seen_next        = seen_reg;
        center_next      = center_reg;
        last_next        = last_reg;
        second_last_next = second_last_reg;
        if (hdr_take)
        begin
            // The magnitude of the most negative count still fits in 16 bits.
            fan_mode_next = !run_count[COUNT_W-1] && (run_count != '0);
            vleft_next    = run_count[COUNT_W-1] ? COUNT_W'(-run_count)
                                                 : COUNT_W'(run_count);
            seen_next     = SEEN_NONE;
        end
        else if (vtx_take)
        begin
            if (seen_reg == SEEN_NONE)
            begin
                center_next = cur;
            end
            second_last_next = last_reg;
            last_next        = cur;
            vleft_next       = vleft_reg - COUNT_W'(1);
            if (seen_reg != SEEN_TWO)
            begin
                seen_next = seen_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        emit             = vtx_take && (seen_reg == SEEN_TWO);
        emit_tri.corner0 = fan_mode_reg ? center_reg : second_last_reg;
        emit_tri.corner1 = last_reg;
        emit_tri.corner2 = cur;
        emit_tri.run_end = (vleft_reg == COUNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_mode_reg <= 1'b0;
            vleft_reg    <= '0;
            seen_reg     <= SEEN_NONE;
        end
        else
        begin
            fan_mode_reg <= fan_mode_next;
            vleft_reg    <= vleft_next;
            seen_reg     <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        center_reg      <= center_next;
        last_reg        <= last_next;
        second_last_reg <= second_last_next;
    end

    `STFA_ASSERT_NOW(a_seen_saturates, clk, rst_n, 1'b1, seen_reg != 2'd3)
    `STFA_ASSERT_NEXT(a_header_restarts, clk, rst_n, hdr_take, seen_reg == SEEN_NONE)
    `STFA_ASSERT_NEXT(a_vertex_counts_down, clk, rst_n, vtx_take,
        vleft_reg == $past(vleft_reg) - COUNT_W'(1))

endmodule

`default_nettype wire

// File: design/stfa_out_buf.sv
// ----------------------------------------------------------------------------
// Strip and fan triangle assembler result buffer
// Two-entry result queue that registers triangles and absorbs a stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "strip_fan_triangle_assembler_macros.svh"

module stfa_out_buf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire stfa_pkg::tri_t push_tri,
    input  wire logic           pop,
    output logic                full,
    output logic                head_valid,
    output stfa_pkg::tri_t      head_tri
);
    import stfa_pkg::*;

    tri_t       slot_reg [2];
    logic       head_reg, head_next;
    logic [1:0] count_reg, count_next;
    logic       tail;

    assign tail       = head_reg ^ count_reg[0];
    assign full       = count_reg[1];
    assign head_valid = (count_reg != 2'd0);
    assign head_tri   = slot_reg[head_reg];

    always_comb
    begin
        head_next  = pop ? ~head_reg : head_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail] <= push_tri;
        end
    end

    `STFA_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, !full)
    `STFA_ASSERT_NOW(a_count_bounded, clk, rst_n, 1'b1, count_reg != 2'd3)
    `STFA_ASSERT_NEXT(a_pop_only_drains, clk, rst_n, pop && !push,
        count_reg == $past(count_reg) - 2'd1)

endmodule

`default_nettype wire

// File: design/strip_fan_triangle_assembler.sv
// ----------------------------------------------------------------------------
// Strip and fan triangle assembler
// Primitive assembly that turns fan and strip vertex runs into triangles.
// ----------------------------------------------------------------------------
// A header item (req_type = 0) opens a run whose signed run_count gives the
// number of vertices: a positive count is a fan, a negative count a strip,
// and zero opens nothing. Vertex items (req_type = 1) carry an index and a
// texture coordinate pair. From the third vertex of a run on, every vertex
// yields one triangle: center, previous, current for a fan, and second-last,
// previous, current for a strip, with no winding alternation. The triangle
// built from the final vertex of a run has run_end set. A header inside an
// open run abandons it, and vertices outside a run are dropped. One item is
// accepted every clock cycle while vtx_stall is low; each triangle is
// registered in a two-entry result queue before it reaches the result port,
// so the input keeps flowing after the result side stalls until the queue
// fills, and vtx_stall rises only when both entries hold triangles.
// ----------------------------------------------------------------------------
`default_nettype none

module strip_fan_triangle_assembler (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Input item channel.
    input  wire logic               vtx_valid,
    output logic                    vtx_stall,
    input  wire logic               req_type,
    input  wire logic signed [15:0] run_count,
    input  wire logic [14:0]        vertex_index,
    input  wire logic signed [15:0] tex_s,
    input  wire logic signed [15:0] tex_t,
    // Triangle result channel.
    output logic                    tri_valid,
    input  wire logic               tri_stall,
    output logic [14:0]             corner0_index,
    output logic signed [15:0]      corner0_s,
    output logic signed [15:0]      corner0_t,
    output logic [14:0]             corner1_index,
    output logic signed [15:0]      corner1_s,
    output logic signed [15:0]      corner1_t,
    output logic [14:0]             corner2_index,
    output logic signed [15:0]      corner2_s,
    output logic signed [15:0]      corner2_t,
    output logic                    run_end
);
    import stfa_pkg::*;

    logic accept;
    logic emit;
    tri_t emit_tri;
    logic buf_full;
    logic pop;
    tri_t head_tri;

    // The stall only depends on registered queue occupancy.
    assign vtx_stall = buf_full;
    assign accept    = vtx_valid && !vtx_stall;
    assign pop       = tri_valid && !tri_stall;

    // Run tracking and triangle formation.
    stfa_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (req_type),
        .run_count    (run_count),
        .vertex_index (vertex_index),
        .tex_s        (tex_s),
        .tex_t        (tex_t),
        .emit         (emit),
        .emit_tri     (emit_tri)
    );

    // Result register with one extra entry to absorb a downstream stall.
    stfa_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (emit),
        .push_tri   (emit_tri),
        .pop        (pop),
        .full       (buf_full),
        .head_valid (tri_valid),
        .head_tri   (head_tri)
    );

    assign corner0_index = head_tri.corner0.index;
    assign corner0_s     = head_tri.corner0.s;
    assign corner0_t     = head_tri.corner0.t;
    assign corner1_index = head_tri.corner1.index;
    assign corner1_s     = head_tri.corner1.s;
    assign corner1_t     = head_tri.corner1.t;
    assign corner2_index = head_tri.corner2.index;
    assign corner2_s     = head_tri.corner2.s;
    assign corner2_t     = head_tri.corner2.t;
    assign run_end       = head_tri.run_end;

endmodule

`default_nettype wire

// File: tb/sv/tb_strip_fan_triangle_assembler.sv
// ----------------------------------------------------------------------------
// Strip and fan triangle assembler testbench
// Drives header and vertex items into the assembler and checks every triangle
// it produces against a cycle-free prediction of fan and strip assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_strip_fan_triangle_assembler;

    import stfa_pkg::*;

    // Cycles without any accepted item on either channel before giving up.
    // The longest legal quiet stretch is one sender gap plus one receiver
    // stall burst, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    // Random items that change the assembler's state (ignored ones excluded).
    localparam int RANDOM_ITEMS   = 700;
    // Runs sent at the end with both sides running flat out.
    localparam int TAIL_RUNS      = 8;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               vtx_valid;
    logic               vtx_stall;
    logic               req_type;
    logic signed [15:0] run_count;
    logic [14:0]        vertex_index;
    logic signed [15:0] tex_s;
    logic signed [15:0] tex_t;
    logic               tri_valid;
    logic               tri_stall;
    logic [14:0]        corner0_index;
    logic signed [15:0] corner0_s;
    logic signed [15:0] corner0_t;
    logic [14:0]        corner1_index;
    logic signed [15:0] corner1_s;
    logic signed [15:0] corner1_t;
    logic [14:0]        corner2_index;
    logic signed [15:0] corner2_s;
    logic signed [15:0] corner2_t;
    logic               run_end;

    // Predicted assembler state, updated once per accepted input item.
    logic        asm_fan    = 1'b0;
    logic [15:0] asm_left   = 16'd0;
    logic [1:0]  asm_seen   = SEEN_NONE;
    vertex_t     asm_center = '0;
    vertex_t     asm_last   = '0;
    vertex_t     asm_second = '0;

    // Triangles the assembler still owes us, oldest first.
    tri_t        pending_triangles[$];

    int          fail_count     = 0;
    int          used_items     = 0;
    int          quiet_cycles   = 0;
    int          src_gap_pct    = 0;
    int          sink_stall_pct = 0;

    strip_fan_triangle_assembler u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .vtx_valid     (vtx_valid),
        .vtx_stall     (vtx_stall),
        .req_type      (req_type),
        .run_count     (run_count),
        .vertex_index  (vertex_index),
        .tex_s         (tex_s),
        .tex_t         (tex_t),
        .tri_valid     (tri_valid),
        .tri_stall     (tri_stall),
        .corner0_index (corner0_index),
        .corner0_s     (corner0_s),
        .corner0_t     (corner0_t),
        .corner1_index (corner1_index),
        .corner1_s     (corner1_s),
        .corner1_t     (corner1_t),
        .corner2_index (corner2_index),
        .corner2_s     (corner2_s),
        .corner2_t     (corner2_t),
        .run_end       (run_end)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Applies one accepted item to the predicted state and queues the triangle
    // it makes, if any. Returns 1 when the item was not simply dropped.
    function automatic bit assemble_triangle(input logic kind,
                                             input logic signed [15:0] count,
                                             input vertex_t cur);
        tri_t made;
        if (kind == REQ_HEADER)
        begin
            // A header always restarts: a zero count leaves no run open, and
            // the most negative count has a magnitude that still fits 16 bits.
            asm_fan  = !count[15] && (count != 16'sd0);
            asm_left = count[15] ? (~count + 16'd1) : count;
            asm_seen = SEEN_NONE;
            return 1'b1;
        end
        if (asm_left == 16'd0)
            return 1'b0;
        if (asm_seen == SEEN_NONE)
            asm_center = cur;
        else if (asm_seen == SEEN_TWO)
        begin
            made.corner0 = asm_fan ? asm_center : asm_second;
            made.corner1 = asm_last;
            made.corner2 = cur;
            made.run_end = (asm_left == 16'd1);
            pending_triangles.push_back(made);
        end
        asm_second = asm_last;
        asm_last   = cur;
        asm_left   = asm_left - 16'd1;
        if (asm_seen != SEEN_TWO)
            asm_seen = asm_seen + 2'd1;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    // Every triangle taken from the result port is matched against the
    // oldest prediction, one field at a time.
    always @(posedge clk)
    begin : check_triangles
        tri_t want;
        if (rst_n && tri_valid && !tri_stall)
        begin
            if (pending_triangles.size() == 0)
                report_mismatch("triangle arrived while none was expected");
            else
            begin
                want = pending_triangles.pop_front();
                check_field("corner0_index", corner0_index, want.corner0.index);
                check_field("corner0_s", corner0_s, want.corner0.s);
                check_field("corner0_t", corner0_t, want.corner0.t);
                check_field("corner1_index", corner1_index, want.corner1.index);
                check_field("corner1_s", corner1_s, want.corner1.s);
                check_field("corner1_t", corner1_t, want.corner1.t);
                check_field("corner2_index", corner2_index, want.corner2.index);
                check_field("corner2_s", corner2_s, want.corner2.s);
                check_field("corner2_t", corner2_t, want.corner2.t);
                check_field("run_end", run_end, want.run_end);
            end
        end
    end

    // The watchdog only counts cycles in which neither channel moves an item,
    // so a long but healthy run never trips it.
    always @(posedge clk)
    begin
        if (!rst_n || (vtx_valid && !vtx_stall) || (tri_valid && !tri_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d triangles outstanding",
                     pending_triangles.size());
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall bursts. A burst is only started at a falling
    // edge, and the stall is lowered at the falling edge that ends it, so each
    // edge sees at most one assignment.
    // ------------------------------------------------------------------------
    initial
    begin
        tri_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && $urandom_range(1, 100) <= sink_stall_pct)
            begin
                tri_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                tri_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    function automatic vertex_t make_vertex(input int idx, input int s, input int t);
        vertex_t v;
        v.index = idx[14:0];
        v.s     = s[15:0];
        v.t     = t[15:0];
        return v;
    endfunction

    function automatic vertex_t rand_vertex();
        return make_vertex($urandom, $urandom, $urandom);
    endfunction

    // Presents one item, possibly after a random gap, and holds it until the
    // assembler takes it. Valid stays high afterwards, so items flow one per
    // clock unless vtx_stall is high; a later gap or a drain lowers it.
    task automatic send_item(input logic kind, input logic signed [15:0] count,
                             input vertex_t v);
        int gap;
        if ($urandom_range(1, 100) <= src_gap_pct)
        begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            vtx_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        vtx_valid    <= 1'b1;
        req_type     <= kind;
        run_count    <= count;
        vertex_index <= v.index;
        tex_s        <= v.s;
        tex_t        <= v.t;
        do
            @(posedge clk);
        while (vtx_stall);
        if (assemble_triangle(kind, count, v))
            used_items++;
    endtask

    // The fields an item does not use still carry random bits, so the
    // assembler is shown to ignore them.
    task automatic send_header(input logic signed [15:0] count);
        send_item(REQ_HEADER, count, rand_vertex());
    endtask

    task automatic send_vertex(input vertex_t v);
        send_item(REQ_VERTEX, 16'($urandom), v);
    endtask

    // Stops sending and waits until every predicted triangle has come out.
    task automatic wait_for_drain();
        @(negedge clk);
        vtx_valid <= 1'b0;
        while (pending_triangles.size() != 0)
            @(posedge clk);
    endtask

    // One run of random shape. Most runs are complete with a small vertex
    // count; some are cut short by the next header, some carry extra vertices
    // past the count, some open with a huge count and are abandoned, and a
    // few items are lone vertices sent without a header of their own.
    task automatic send_random_run();
        int              pick;
        int              mag;
        int              nvtx;
        bit              neg;
        logic signed [15:0] count;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            send_vertex(rand_vertex());
            return;
        end
        if (pick <= 15)
            mag = $urandom_range(3, 12);
        else if (pick <= 17)
            mag = $urandom_range(0, 2);
        else if (pick == 18)
            mag = $urandom_range(13, 40);
        else
            mag = $urandom_range(0, 32768);
        neg   = $urandom_range(0, 1);
        count = 16'(neg ? -mag : mag);
        pick  = $urandom_range(0, 9);
        if (mag > 40)
            nvtx = $urandom_range(0, 8);
        else if (pick == 0)
            nvtx = $urandom_range(0, mag);
        else if (pick == 1)
            nvtx = mag + $urandom_range(1, 3);
        else
            nvtx = mag;
        send_header(count);
        repeat (nvtx) send_vertex(rand_vertex());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A fan of four vertices with the index and coordinates at their extremes:
    // two triangles share the first vertex, and the second closes the run.
    task automatic test_fan_directed();
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        send_header(16'sd4);
        send_vertex(make_vertex(0, -32768, 32767));
        send_vertex(make_vertex(32767, 32767, -32768));
        send_vertex(make_vertex('h5555, 0, -1));
        send_vertex(make_vertex('h2AAA, 1, 0));
    endtask

    // A strip of four vertices: the first corner slides along the strip and
    // the winding is never flipped.
    task automatic test_strip_directed();
        send_header(-16'sd4);
        send_vertex(make_vertex(32767, -1, -32768));
        send_vertex(make_vertex(0, 0, 32767));
        send_vertex(make_vertex('h2AAA, 'h5555, -'h5556));
        send_vertex(make_vertex('h5555, -'h5556, 'h5555));
    endtask

    // Zero count, vertices past the end of a run, runs too short to make a
    // triangle, the most negative and most positive counts, and a header that
    // abandons an open run.
    task automatic test_run_special_cases();
        // A zero count opens nothing, so the vertex after it is dropped.
        send_header(16'sd0);
        send_vertex(rand_vertex());
        // A run of one makes no triangle; the vertex after it lies past the
        // count and is dropped.
        send_header(16'sd1);
        send_vertex(rand_vertex());
        send_vertex(rand_vertex());
        // A strip of two makes no triangle either.
        send_header(-16'sd2);
        send_vertex(rand_vertex());
        send_vertex(rand_vertex());
        // The most negative count is a very long strip; its third vertex makes
        // a triangle that does not close the run.
        send_header(-16'sd32768);
        repeat (3) send_vertex(rand_vertex());
        // The most positive count abandons that strip mid-run, and is itself
        // abandoned by the header of the next test.
        send_header(16'sd32767);
        repeat (2) send_vertex(rand_vertex());
    endtask

    // The sender holds back until every triangle of a fan has been taken,
    // while the result side stalls heavily.
    task automatic test_pause_until_drained();
        sink_stall_pct = 40;
        send_header(16'sd6);
        repeat (6) send_vertex(rand_vertex());
        wait_for_drain();
        sink_stall_pct = 20;
    endtask

    // Long random stream. Idling odds change every few runs, including
    // stretches with no idling at all, so gaps land on every point of a run.
    task automatic test_random_runs();
        int start;
        int runs;
        start = used_items;
        runs  = 0;
        while (used_items - start < RANDOM_ITEMS)
        begin
            if (runs % 6 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: src_gap_pct = 0;
                    1: src_gap_pct = 15;
                    default: src_gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: sink_stall_pct = 0;
                    1: sink_stall_pct = 10;
                    default: sink_stall_pct = 30;
                endcase
            end
            send_random_run();
            if ($urandom_range(0, 39) == 0)
                wait_for_drain();
            runs++;
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_quiet_tail();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        repeat (TAIL_RUNS) send_random_run();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        vtx_valid    = 1'b0;
        req_type     = REQ_HEADER;
        run_count    = '0;
        vertex_index = '0;
        tex_s        = '0;
        tex_t        = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_fan_directed();
        test_strip_directed();
        test_run_special_cases();
        test_pause_until_drained();
        test_random_runs();
        test_quiet_tail();

        // Let the last triangles out, then give the block a few more cycles
        // to show that nothing unexpected follows.
        wait_for_drain();
        repeat (8) @(posedge clk);
        if (pending_triangles.size() != 0)
            report_mismatch($sformatf("%0d triangles never arrived",
                                      pending_triangles.size()));
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
